>>> design/rmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmr_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int RES_WIDTH     = 32;
  localparam int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic signed [OPERAND_WIDTH-1:0] den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic signed [OPERAND_WIDTH-1:0] den_b;
  } rmr_in_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] prod_num;
    logic signed [RES_WIDTH-1:0] prod_den;
    logic                        div_error;
  } rmr_out_t;

  // One classified job handed from the front to the back.
  typedef struct packed {
    logic signed [PROD_WIDTH-1:0] pn;
    logic signed [PROD_WIDTH-1:0] pd;
    logic                         zero;
  } rmr_job_t;

  typedef struct packed {
    logic                         start;
    logic signed [PROD_WIDTH-1:0] dividend;
    logic signed [PROD_WIDTH-1:0] divisor;
  } rmr_div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [PROD_WIDTH-1:0] quo;
    logic signed [PROD_WIDTH-1:0] rem;
  } rmr_div_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GCD,
    B_GCD_WAIT,
    B_DIVN_GO,
    B_DIVN_WAIT,
    B_DIVD_GO,
    B_DIVD_WAIT,
    B_OUT
  } rmr_back_state_t;

endpackage
`default_nettype wire

>>> design/rmr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rmr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire rmr_pkg::rmr_in_t  operands,
  output logic                   q_push,
  output rmr_pkg::rmr_job_t      q_job,
  input  wire logic              q_full
);
  import rmr_pkg::*;

  logic                         f_valid;
  logic signed [PROD_WIDTH-1:0] f_pn;
  logic signed [PROD_WIDTH-1:0] f_pd;

  assign q_push = f_valid && !q_full;
  assign full   = f_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (push && !full) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      f_pn <= $signed(operands.num_a) * $signed(operands.num_b);
      f_pd <= $signed(operands.den_a) * $signed(operands.den_b);
    end
  end

  // Both products zero means the divisor would be zero.
  always_comb begin
    q_job.pn   = f_pn;
    q_job.pd   = f_pd;
    q_job.zero = (f_pn == '0) && (f_pd == '0);
  end

endmodule
`default_nettype wire

>>> design/rmr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rmr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire rmr_pkg::rmr_job_t wr_job,
  output logic                   q_full,
  input  wire logic              rd,
  output rmr_pkg::rmr_job_t      rd_job,
  output logic                   q_empty
);
  import rmr_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  rmr_job_t          slots [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == (PtrW+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule
`default_nettype wire

>>> design/rmr_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module rmr_divider (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rmr_pkg::rmr_div_req_t req,
  output rmr_pkg::rmr_div_rsp_t     rsp
);
  import rmr_pkg::*;

  localparam int CntW = $clog2(PROD_WIDTH);

  logic                  busy;
  logic                  done;
  logic [CntW-1:0]       cnt;
  logic [PROD_WIDTH:0]   acc;
  logic [PROD_WIDTH-1:0] quo;
  logic [PROD_WIDTH-1:0] dvs;
  logic                  neg_q;
  logic                  neg_r;
  logic [PROD_WIDTH:0]   acc_sh;
  logic [PROD_WIDTH:0]   diff;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign acc_sh = {acc[PROD_WIDTH-1:0], quo[PROD_WIDTH-1]};
  assign diff   = acc_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(PROD_WIDTH-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      acc   <= '0;
      quo   <= req.dividend[PROD_WIDTH-1] ? PROD_WIDTH'(-req.dividend) : req.dividend;
      dvs   <= req.divisor[PROD_WIDTH-1]  ? PROD_WIDTH'(-req.divisor)  : req.divisor;
      neg_q <= req.dividend[PROD_WIDTH-1] ^ req.divisor[PROD_WIDTH-1];
      neg_r <= req.dividend[PROD_WIDTH-1];
    end else if (busy) begin
      if (!diff[PROD_WIDTH]) begin
        acc <= diff;
        quo <= {quo[PROD_WIDTH-2:0], 1'b1};
      end else begin
        acc <= acc_sh;
        quo <= {quo[PROD_WIDTH-2:0], 1'b0};
      end
    end
  end

  // Truncated rules: quotient sign from both operands, remainder from the dividend.
  always_comb begin
    rsp.done = done;
    rsp.quo  = neg_q ? -$signed(quo) : $signed(quo);
    rsp.rem  = neg_r ? -$signed(acc[PROD_WIDTH-1:0]) : $signed(acc[PROD_WIDTH-1:0]);
  end

endmodule
`default_nettype wire

>>> design/rmr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rmr_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rmr_pkg::rmr_job_t q_job,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output rmr_pkg::rmr_out_t      result
);
  import rmr_pkg::*;

  rmr_back_state_t              state;
  rmr_back_state_t              state_next;
  rmr_div_req_t                 req;
  rmr_div_rsp_t                 rsp;
  logic signed [PROD_WIDTH-1:0] pn;
  logic signed [PROD_WIDTH-1:0] pd;
  logic signed [PROD_WIDTH-1:0] a;
  logic signed [PROD_WIDTH-1:0] b;
  logic signed [PROD_WIDTH-1:0] qn;
  logic signed [PROD_WIDTH-1:0] qd;
  logic                         zero;
  logic                         out_valid;
  logic                         load_out;

  rmr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign empty    = !out_valid;
  assign load_out = (state == B_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    req.start    = 1'b0;
    req.dividend = a;
    req.divisor  = b;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_job.zero ? B_OUT : B_GCD;
        end
      end
      B_GCD: begin
        if (b == '0) begin
          state_next = B_DIVN_GO;
        end else begin
          req.start  = 1'b1;
          state_next = B_GCD_WAIT;
        end
      end
      B_GCD_WAIT: begin
        if (rsp.done) state_next = B_GCD;
      end
      B_DIVN_GO: begin
        req.start    = 1'b1;
        req.dividend = pn;
        req.divisor  = a;
        state_next   = B_DIVN_WAIT;
      end
      B_DIVN_WAIT: begin
        if (rsp.done) state_next = B_DIVD_GO;
      end
      B_DIVD_GO: begin
        req.start    = 1'b1;
        req.dividend = pd;
        req.divisor  = a;
        state_next   = B_DIVD_WAIT;
      end
      B_DIVD_WAIT: begin
        if (rsp.done) state_next = B_OUT;
      end
      B_OUT: begin
        if (!out_valid || pop) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pn   <= q_job.pn;
          pd   <= q_job.pd;
          zero <= q_job.zero;
          a    <= q_job.pn;
          b    <= q_job.pd;
        end
      end
      B_GCD_WAIT: begin
        if (rsp.done) begin
          a <= b;
          b <= rsp.rem;
        end
      end
      B_DIVN_WAIT: begin
        if (rsp.done) qn <= rsp.quo;
      end
      B_DIVD_WAIT: begin
        if (rsp.done) qd <= rsp.quo;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.prod_num  <= zero ? '0 : RES_WIDTH'(qn);
      result.prod_den  <= zero ? '0 : RES_WIDTH'(qd);
      result.div_error <= zero;
    end
  end

endmodule
`default_nettype wire

>>> design/rational_multiply_reduce_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Multiplies two signed fractions and reduces the product by a Euclid divisor.
// Input channel: drive a word on operands and raise push; it is taken at a
// clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result word is on result;
// raise pop to take it at the next edge.
// The front multiplies, registers the products and hands them to a two-entry
// queue. The back runs Euclid and the two final divisions on one shared
// iterative divider that makes one quotient bit per cycle. An item's time in
// the back grows with the number of Euclid remainder steps; a 0/0 item skips
// the divider and goes straight to the result register.
// Items are worked one at a time in the back; the front keeps taking words
// until the queue and its own stage are filled.
// When the receiver stalls, the finished word is held on result and the back
// waits before loading the next one; full rises once the queue backs up.
// A synchronous reset empties the queue and the result register.
module rational_multiply_reduce_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire rmr_pkg::rmr_in_t operands,
  output logic                  empty,
  input  wire logic             pop,
  output rmr_pkg::rmr_out_t     result
);
  import rmr_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  rmr_job_t wr_job;
  rmr_job_t rd_job;

  rmr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .operands (operands),
    .q_push   (q_push),
    .q_job    (wr_job),
    .q_full   (q_full)
  );

  rmr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_job  (wr_job),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_job  (rd_job),
    .q_empty (q_empty)
  );

  rmr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_job   (rd_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

>>> design/rmr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rmr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire rmr_pkg::rmr_out_t result
);
  import rmr_pkg::*;

  // Reset leaves no result word waiting and room for input.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full left set after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result word changed");

  // The error word is always 0/0.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.div_error) |-> (result.prod_num == '0 && result.prod_den == '0))
    else $error("error word is not 0/0");

  // Without the error, a nonzero divisor leaves at least one nonzero part.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.div_error) |-> (result.prod_num != '0 || result.prod_den != '0))
    else $error("reduced word is 0/0 without error");

endmodule

bind rational_multiply_reduce_top rmr_checker u_rmr_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
`default_nettype wire
